@@ src/cai_pkg.sv @@
// ----------------------------------------------------------------------------
// cai_pkg
// Constants, register indexes and helpers for the circular arc interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cai_pkg;

  localparam int PoseW = 32;
  localparam int AngW  = 44;
  localparam int CordW = 34;

  localparam logic [27:0] TWO_PI_Q24  = 28'd105414357;
  localparam logic [27:0] PI_Q24      = 28'd52707179;
  localparam logic [27:0] HALF_PI_Q24 = 28'd26353589;
  localparam logic signed [CordW-1:0] CORDIC_K_Q30 = 34'sd652032874;

  localparam logic [1:0] REG_ARC_LENGTH  = 2'd0;
  localparam logic [1:0] REG_TURN_RADIUS = 2'd1;
  localparam logic [1:0] REG_DIRECTION   = 2'd2;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837830;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd31: v = 31'd0;
      default: v = 31'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/circular_arc_interpolator.sv @@
// ----------------------------------------------------------------------------
// circular_arc_interpolator
// Steps a pose along a circular arc; start loads a pose, each tick of a running arc one step.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries op, start_x, start_y,
// start_heading; op 0 starts an arc from the given pose, op 1 is a tick.
// Output channel (out_valid/out_ready) returns one pose per input transfer,
// with moving, last and bad_radius flags. The APB port writes arc_length,
// turn_radius and direction at 0x0, 0x4, 0x8; writes take effect on the
// next start.
// One item is processed at a time. A tick runs the angle sum, angle reduction,
// CORDIC_ITERS CORDIC iterations and a shared multiplier used twice. A start
// skips the angle sum and, when the arc moves, adds the bit-serial divider
// that forms the angle step. An idle tick goes straight to the output. The
// input is ready again the cycle after the result is registered.
// If the receiver stalls, a finished result waits until the output register
// frees. Reset clears the pose, arc state and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_arc_interpolator
  import cai_pkg::*;
#(
  parameter int STEPS        = 100,
  parameter int CORDIC_ITERS = 24
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                op,
  input  wire signed  [31:0] start_x,
  input  wire signed  [31:0] start_y,
  input  wire signed  [31:0] start_heading,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_heading,
  output logic               moving,
  output logic               last,
  output logic               bad_radius,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [3:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int IW     = $clog2(CORDIC_ITERS);
  localparam int DENW   = 32 + $clog2(STEPS + 1);
  localparam int NUMW   = 56;
  localparam int RED_N  = 17;
  localparam logic [AngW-1:0] RED_DV0 = AngW'(TWO_PI_Q24) << (RED_N - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ANGLE, S_PREP, S_REDUCE, S_FOLD, S_CORDIC, S_FIX,
    S_MULS, S_MULC, S_SUM, S_DIV, S_EMIT
  } state_t;

  state_t state;

  logic [30:0]        arc_length;
  logic signed [31:0] turn_radius;
  logic [1:0]         direction;

  logic signed [31:0] centre_x, centre_y, base_angle, angle_step, arc_radius;
  logic [10:0]        step_index;
  logic               running;
  logic signed [31:0] held_x, held_y, held_h;
  logic               is_start, f_moving, f_last, f_bad;
  logic signed [31:0] in_x, in_y;

  logic signed [AngW-1:0] ang;
  logic [AngW-1:0]        rem, dv;
  logic [4:0]             cnt;
  logic                   flip;
  logic signed [CordW-1:0] cx, cy, cz, sn, cs;
  logic [IW-1:0]          iter;
  logic signed [35:0]     ps, pc;

  logic [DENW-1:0]  den;
  logic [NUMW-1:0]  num, quo;
  logic [DENW:0]    drem;
  logic [5:0]       dcnt;

  // datapath helpers
  logic [AngW-1:0]         ang_mag;
  logic signed [27:0]      m0, m1, m2;
  logic                    flip_n;
  logic signed [CordW-1:0] dx, dy, atn;
  logic signed [65:0]      prod;
  logic signed [CordW-1:0] mul_b;
  logic signed [35:0]      prod_rnd;
  logic [DENW:0]           drem_sh;
  logic [31:0]             r_abs;
  logic [DENW-1:0]         den_c;
  logic [NUMW-1:0]         num_c;
  logic [30:0]             q_sat;
  logic                    step_neg;
  logic                    cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (paddr[3:2])
      REG_ARC_LENGTH:  prdata = {1'b0, arc_length};
      REG_TURN_RADIUS: prdata = turn_radius;
      REG_DIRECTION:   prdata = {30'd0, direction};
      default:         prdata = 32'd0;
    endcase
  end

  assign ang_mag = ang[AngW-1] ? AngW'(-ang) : AngW'(ang);

  always_comb begin
    m0 = (ang[AngW-1] && rem != '0) ? $signed(TWO_PI_Q24 - rem[27:0])
                                    : $signed(rem[27:0]);
    m1 = (m0 > $signed(PI_Q24)) ? m0 - $signed(TWO_PI_Q24) : m0;
    flip_n = 1'b0;
    m2 = m1;
    if (m1 > $signed(HALF_PI_Q24)) begin
      m2 = m1 - $signed(PI_Q24);
      flip_n = 1'b1;
    end else if (m1 < -$signed(HALF_PI_Q24)) begin
      m2 = m1 + $signed(PI_Q24);
      flip_n = 1'b1;
    end
  end

  assign dx  = cy >>> iter;
  assign dy  = cx >>> iter;
  assign atn = $signed({3'b000, atan_q30(5'(iter))});

  assign mul_b    = (state == S_MULS) ? sn : cs;
  assign prod     = arc_radius * mul_b;
  assign prod_rnd = 36'((prod + 66'sd536870912) >>> 30);

  assign drem_sh = {drem[DENW-1:0], num[NUMW-1]};

  assign r_abs    = arc_radius[31] ? 32'(-arc_radius) : 32'(arc_radius);
  assign den_c    = DENW'(STEPS) * DENW'(r_abs);
  assign num_c    = NUMW'({arc_length, 24'd0}) + NUMW'(den_c >> 1);
  assign q_sat    = (quo[NUMW-1:31] != '0) ? 31'h7fffffff : quo[30:0];
  assign step_neg = arc_radius[31] ^ direction[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      arc_length  <= '0;
      turn_radius <= 32'sd65536;
      direction   <= '0;
      centre_x    <= '0;
      centre_y    <= '0;
      base_angle  <= '0;
      angle_step  <= '0;
      arc_radius  <= '0;
      step_index  <= '0;
      running     <= 1'b0;
      held_x      <= '0;
      held_y      <= '0;
      held_h      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ARC_LENGTH:  arc_length  <= pwdata[30:0];
          REG_TURN_RADIUS: turn_radius <= pwdata;
          REG_DIRECTION:   direction   <= pwdata[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_start <= ~op;
            in_x     <= start_x;
            in_y     <= start_y;
            f_moving <= 1'b0;
            f_last   <= 1'b0;
            f_bad    <= 1'b0;
            if (!op) begin
              arc_radius <= turn_radius;
              ang        <= AngW'(start_heading);
              state      <= S_PREP;
            end else if (running) begin
              step_index <= step_index + 11'd1;
              state      <= S_ANGLE;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_ANGLE: begin
          ang   <= AngW'(base_angle)
                   + AngW'($signed({1'b0, step_index})) * AngW'(angle_step);
          state <= S_PREP;
        end
        S_PREP: begin
          rem   <= ang_mag;
          dv    <= RED_DV0;
          cnt   <= 5'(RED_N - 1);
          state <= S_REDUCE;
        end
        S_REDUCE: begin
          if (rem >= dv) rem <= rem - dv;
          dv  <= dv >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_FOLD;
        end
        S_FOLD: begin
          flip  <= flip_n;
          cz    <= CordW'(m2) <<< 6;
          cx    <= CORDIC_K_Q30;
          cy    <= '0;
          iter  <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - atn;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + atn;
          end
          iter <= iter + 1'b1;
          if (iter == IW'(CORDIC_ITERS - 1)) state <= S_FIX;
        end
        S_FIX: begin
          sn    <= flip ? -cy : cy;
          cs    <= flip ? -cx : cx;
          state <= S_MULS;
        end
        S_MULS: begin
          ps    <= prod_rnd;
          state <= S_MULC;
        end
        S_MULC: begin
          pc    <= prod_rnd;
          state <= S_SUM;
        end
        S_SUM: begin
          if (is_start) begin
            centre_x   <= sat32(48'(in_x) - 48'(ps));
            centre_y   <= sat32(48'(in_y) + 48'(pc));
            base_angle <= ang[31:0];
            step_index <= '0;
            held_x     <= in_x;
            held_y     <= in_y;
            held_h     <= ang[31:0];
            f_bad      <= (arc_radius == 0);
            if (arc_radius == 0 || direction == 2'd0 || arc_length == '0) begin
              angle_step <= '0;
              running    <= 1'b0;
              state      <= S_EMIT;
            end else begin
              running <= 1'b0;
              den     <= den_c;
              num     <= num_c;
              drem    <= '0;
              quo     <= '0;
              dcnt    <= 6'(NUMW - 1);
              state   <= S_DIV;
            end
          end else begin
            held_x   <= sat32(48'(ps) + 48'(centre_x));
            held_y   <= sat32(48'(centre_y) - 48'(pc));
            held_h   <= sat32(48'(ang));
            f_moving <= 1'b1;
            f_last   <= (step_index >= 11'(STEPS));
            if (step_index >= 11'(STEPS)) running <= 1'b0;
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          if (drem_sh >= {1'b0, den}) begin
            drem <= drem_sh - {1'b0, den};
            quo  <= {quo[NUMW-2:0], 1'b1};
          end else begin
            drem <= drem_sh;
            quo  <= {quo[NUMW-2:0], 1'b0};
          end
          num  <= num << 1;
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) state <= S_EMIT;
        end
        S_EMIT: begin
          if (is_start && f_bad == 1'b0 && direction != 2'd0 && arc_length != '0
              && arc_radius != 0 && !running) begin
            angle_step <= step_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
            running    <= 1'b1;
          end
          if (!out_valid || out_ready) begin
            pos_x       <= held_x;
            pos_y       <= held_y;
            pos_heading <= held_h;
            moving      <= f_moving;
            last        <= f_last;
            bad_radius  <= f_bad;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_moving: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> moving)
    else $error("last step without motion");

  a_bad_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_radius |-> !moving && !last)
    else $error("motion on zero radius");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

`default_nettype wire

@@ test/circular_arc_interpolator_test.sv @@
// ----------------------------------------------------------------------------
// circular_arc_interpolator_test
// Self-checking bench for the circular arc interpolator: a directed table of
// starts and ticks, then random arcs under several register settings, each
// result compared against a fixed-point predictor of the arc stepping.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module circular_arc_interpolator_test
  import cai_pkg::*;
;

  localparam int NSTEPS = 100;
  localparam int ITERS = 24;
  localparam int WATCH = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam longint TWOPI = 105414357;
  localparam longint PI = 52707179;
  localparam longint HALFPI = 26353589;
  localparam longint KGAIN = 652032874;
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
    logic mv;
    logic lst;
    logic bad;
  } pose_t;

  typedef struct {
    logic o;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
    bit known;
    pose_t res;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, op = 0, out_ready = 0;
  logic signed [31:0] start_x = 0, start_y = 0, start_heading = 0;
  logic out_valid, in_ready, moving, last, bad_radius, pready;
  logic signed [31:0] pos_x, pos_y, pos_heading;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  circular_arc_interpolator uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // predictor state
  longint unsigned p_len;
  int p_rad, p_dir, c_x, c_y, b_ang, a_stp, a_rad, h_pose[3];
  int unsigned s_idx;
  bit run_on;
  pose_t poses_due[$];
  int errors = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_cnt = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  task automatic rotate(input longint a, output longint sn, output longint cs);
    longint m, x, y, z, t, dx, dy;
    bit flip;
    m = a % TWOPI;
    flip = 0;
    if (m < 0) m += TWOPI;
    if (m > PI) m -= TWOPI;
    if (m > HALFPI) begin
      m -= PI;
      flip = 1;
    end else if (m < -HALFPI) begin
      m += PI;
      flip = 1;
    end
    x = KGAIN;
    y = 0;
    z = m * 64;
    for (int i = 0; i < ITERS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        t = x - dx; y = y + dy; z -= longint'(atan_q30(i[4:0]));
      end else begin
        t = x + dx; y = y - dy; z += longint'(atan_q30(i[4:0]));
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = y;
    cs = x;
  endtask

  function automatic longint rmul(int r, longint t);
    return asr(longint'(r) * t + (64'sd1 <<< 29), 30);
  endfunction

  task automatic predict_pose(input logic o, input int x, input int y, input int h,
                              output pose_t p);
    longint sn, cs, a;
    longint unsigned ar, den, q;
    bit bad;
    p = '0;
    if (o == OP_START) begin
      bad = (p_rad == 0);
      rotate(h, sn, cs);
      c_x = sat(longint'(x) - rmul(p_rad, sn));
      c_y = sat(longint'(y) + rmul(p_rad, cs));
      b_ang = h;
      a_rad = p_rad;
      s_idx = 0;
      h_pose = '{x, y, h};
      if (bad || p_dir == 0 || p_len == 0) begin
        a_stp = 0;
        run_on = 0;
      end else begin
        ar = (p_rad < 0) ? -longint'(p_rad) : p_rad;
        den = NSTEPS * ar;
        q = ((p_len << 24) + den / 2) / den;
        if (q > 64'h7fffffff) q = 64'h7fffffff;
        a_stp = ((p_rad < 0) != (p_dir < 0)) ? -int'(q) : int'(q);
        run_on = 1;
      end
      p.bad = bad;
    end else if (run_on) begin
      s_idx = (s_idx + 1) & 11'h7ff;
      a = longint'(b_ang) + longint'(s_idx) * longint'(a_stp);
      rotate(a, sn, cs);
      h_pose[0] = sat(rmul(a_rad, sn) + c_x);
      h_pose[1] = sat(c_y - rmul(a_rad, cs));
      h_pose[2] = sat(a);
      p.mv = 1;
      p.lst = (s_idx >= NSTEPS);
      if (p.lst) run_on = 0;
    end
    p.x = h_pose[0];
    p.y = h_pose[1];
    p.h = h_pose[2];
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ARC_LENGTH: p_len = v[30:0];
      REG_TURN_RADIUS: p_rad = v;
      default: p_dir = (v[1:0] == 0) ? 0 : (v[1:0] == 1) ? 1 : -1;
    endcase
  endtask

  // valid stays up after a transfer until the next offer, gap or drain
  task automatic offer(input logic o, input int x, input int y, input int h,
                       input bit known, input pose_t res);
    pose_t p;
    predict_pose(o, x, y, h, p);
    if (known && p !== res) begin
      $display("%0t table row disagrees: table %h predictor %h", $time, res, p);
      errors++;
    end
    poses_due.push_back(p);
    in_valid <= 1; op <= o;
    start_x <= x; start_y <= y; start_heading <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (poses_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic gap;
    if ($urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic int rnd_field;
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES) hold_done <= 1;
      end
      out_ready <= !(hold_req && !hold_done) && ($urandom_range(4) != 0);
      if (out_valid && out_ready) begin
        if (poses_due.size() == 0) begin
          $display("%0t transfer with nothing pending: %h %h %h", $time,
                   pos_x, pos_y, pos_heading);
          errors++;
        end else if (poses_due[0] !== {pos_x, pos_y, pos_heading, moving, last,
                                        bad_radius}) begin
          $display("%0t mismatch: expected %h actual %h", $time, poses_due[0],
                   {pos_x, pos_y, pos_heading, moving, last, bad_radius});
          errors++;
          void'(poses_due.pop_front());
        end else begin
          void'(poses_due.pop_front());
        end
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCH) begin
      $display("FAIL circular_arc_interpolator");
      $finish;
    end
  end

  row_t table_rows[$];
  pose_t z;

  initial begin
    int n;
    int cfg;
    p_len = 0; p_rad = 65536; p_dir = 0;
    c_x = 0; c_y = 0; b_ang = 0; a_stp = 0; a_rad = 0; s_idx = 0; run_on = 0;
    h_pose = '{0, 0, 0};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    z = '0;
    // directed: idle tick after reset, stopped start, extremes
    table_rows.push_back('{OP_TICK, 0, 0, 0, 1, z});
    table_rows.push_back('{OP_START, 32'h7fffffff, 32'h80000000, 0, 1,
                           '{32'h7fffffff, 32'h80000000, 0, 0, 0, 0}});
    table_rows.push_back('{OP_TICK, 0, 0, 0, 1,
                           '{32'h7fffffff, 32'h80000000, 0, 0, 0, 0}});
    foreach (table_rows[i])
      offer(table_rows[i].o, table_rows[i].x, table_rows[i].y, table_rows[i].h,
            table_rows[i].known, table_rows[i].res);
    drain();
    write_reg(REG_TURN_RADIUS, 0);
    write_reg(REG_DIRECTION, 2'b01);
    write_reg(REG_ARC_LENGTH, 32'h7fffffff);
    offer(OP_START, 5, 6, 7, 1, '{5, 6, 7, 0, 0, 1});
    offer(OP_TICK, 0, 0, 0, 1, '{5, 6, 7, 0, 0, 0});
    drain();
    write_reg(REG_TURN_RADIUS, 1);
    write_reg(REG_DIRECTION, 2'b10);
    offer(OP_START, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, z);
    repeat (3) offer(OP_TICK, 0, 0, 0, 0, z);
    offer(OP_START, 0, 0, 32'h80000000, 0, z);
    repeat (12) offer(OP_TICK, 0, 0, 0, 0, z);
    drain();
    write_reg(REG_TURN_RADIUS, 32'h80000000);
    write_reg(REG_DIRECTION, 2'b11);
    write_reg(REG_ARC_LENGTH, 65536 * 10);
    offer(OP_START, 100, -100, 26353589, 0, z);
    repeat (4) offer(OP_TICK, 0, 0, 0, 0, z);
    drain();
    // random phases
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      cfg = $urandom_range(3);
      write_reg(REG_ARC_LENGTH, cfg == 0 ? 32'hffffffff : cfg == 1 ? 0 :
                $urandom_range(1, 65536 * 400));
      write_reg(REG_TURN_RADIUS, ph == 7 ? 0 : cfg == 0 ? 32'h7fffffff :
                ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1, 65536 * 200)));
      write_reg(REG_DIRECTION, $urandom);
      if (ph == 3) hold_req = 1;
      while (n < (ph + 1) * 210) begin
        if ($urandom_range(9) == 0) offer(1'($urandom_range(1)), rnd_field(),
                                           rnd_field(), rnd_field(), 0, z);
        else begin
          offer(OP_START, rnd_field(), rnd_field(), rnd_field(), 0, z);
          repeat ($urandom_range(1, 110)) begin
            offer(OP_TICK, $urandom, $urandom, $urandom, 0, z);
            gap();
            n++;
          end
        end
        n++;
      end
      drain();
    end
    drain();
    if (errors == 0 && poses_due.size() == 0) begin
      $display("PASS circular_arc_interpolator");
    end else begin
      $display("FAIL circular_arc_interpolator");
    end
    $finish;
  end

endmodule

@@ circular_arc_interpolator.f @@
src/cai_pkg.sv
src/circular_arc_interpolator.sv
test/circular_arc_interpolator_test.sv
